### rtl/rde_pkg.sv
// Shared types and constants for the reversible deque engine.
`timescale 1ns / 1ps

package rde_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 11;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_PUSH    = 3'd1,
        OP_REVERSE = 3'd2,
        OP_DELETE  = 3'd3,
        OP_READ    = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_DEL_EMPTY   = 3'd1,
        ST_FULL        = 3'd2,
        ST_ERR_PENDING = 3'd3,
        ST_NOTHING     = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_RDATA = 1'b1
    } t_state;

endpackage

### rtl/rde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rde_ram #(
    parameter int WIDTH = rde_pkg::VALUE_W,
    parameter int DEPTH = rde_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/reversible_deque_engine.sv
// Top level: deque in a ring RAM with a direction flag and sticky delete error.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_operation,      | into block
//          | i_push_value                              |
//  out     | o_out_valid, i_out_ready, o_element,      | out of block
//          | o_status, o_last, o_occupancy, o_reversed |
//
// Every item except a read that pops is answered from S_IDLE; a popping read
// goes on through S_RDATA, since the ring RAM registers its read data.
// The result sits in an output register; a new item is taken while the old
// result leaves in the same cycle.
// A stalled output holds the input side off once the output register is full.
// Reset (i_rst_n low, synchronous) empties the deque and clears both flags;
// RAM contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module reversible_deque_engine #(
    parameter int DEPTH = rde_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rde_pkg::OP_W-1:0]      i_operation,
    input  logic signed [rde_pkg::VALUE_W-1:0] i_push_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [rde_pkg::VALUE_W-1:0] o_element,
    output logic [rde_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last,
    output logic [rde_pkg::OCC_W-1:0]     o_occupancy,
    output logic                          o_reversed
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = rde_pkg::VALUE_W;
    localparam int SW = rde_pkg::STATUS_W;
    localparam int OW = rde_pkg::OCC_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    rde_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;
    logic          r_err, n_err;

    logic          r_out_valid, n_out_valid;
    logic [VW-1:0] r_element, n_element;
    logic [SW-1:0] r_status, n_status;
    logic          r_last, n_last;

    logic          w_accept;
    logic          w_load;
    logic          w_empty;
    logic [PW-1:0] w_tail_prev;
    logic [PW-1:0] w_head_next;
    logic [PW-1:0] w_tail_next;

    logic          w_wr_en;
    logic          w_rd_en;
    logic [PW-1:0] w_rd_addr;
    logic [VW-1:0] w_rd_data;
    logic [CW+OW-1:0] w_cnt_ext;

    assign w_empty     = (r_count == '0);
    assign w_tail_prev = (r_tail == '0) ? PTR_LAST : r_tail - PW'(1);
    assign w_head_next = (r_head == PTR_LAST) ? '0 : r_head + PW'(1);
    assign w_tail_next = (r_tail == PTR_LAST) ? '0 : r_tail + PW'(1);

    assign o_in_ready = (r_state == rde_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    rde_ram #(
        .WIDTH(VW),
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_tail),
        .i_wr_data(i_push_value),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_rev     = r_rev;
        n_err     = r_err;
        n_element = r_element;
        n_status  = r_status;
        n_last    = r_last;
        w_load    = 1'b0;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_addr = r_rev ? w_tail_prev : r_head;

        unique case (r_state)
            rde_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_load    = 1'b1;
                    n_element = '0;
                    n_status  = SW'(rde_pkg::ST_OK);
                    n_last    = 1'b0;
                    unique case (i_operation)
                        rde_pkg::OP_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_rev   = 1'b0;
                            n_err   = 1'b0;
                        end
                        rde_pkg::OP_PUSH: begin
                            if (r_count == CNT_FULL) begin
                                n_status = SW'(rde_pkg::ST_FULL);
                            end else begin
                                w_wr_en = 1'b1;
                                n_tail  = w_tail_next;
                                n_count = r_count + CW'(1);
                            end
                        end
                        rde_pkg::OP_REVERSE: begin
                            if (r_err) begin
                                n_status = SW'(rde_pkg::ST_ERR_PENDING);
                            end else begin
                                n_rev = !r_rev;
                            end
                        end
                        rde_pkg::OP_DELETE, rde_pkg::OP_READ: begin
                            priority if (r_err) begin
                                n_status = SW'(rde_pkg::ST_ERR_PENDING);
                            end else if (w_empty) begin
                                if (i_operation == rde_pkg::OP_DELETE) begin
                                    n_err    = 1'b1;
                                    n_status = SW'(rde_pkg::ST_DEL_EMPTY);
                                end else begin
                                    n_status = SW'(rde_pkg::ST_NOTHING);
                                end
                            end else begin
                                if (r_rev) begin
                                    n_tail = w_tail_prev;
                                end else begin
                                    n_head = w_head_next;
                                end
                                n_count = r_count - CW'(1);
                                // a popping read waits in S_RDATA for the registered RAM data
                                if (i_operation == rde_pkg::OP_READ) begin
                                    w_rd_en = 1'b1;
                                    w_load  = 1'b0;
                                    n_state = rde_pkg::S_RDATA;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rde_pkg::S_RDATA: begin
                w_load    = 1'b1;
                n_element = w_rd_data;
                n_status  = SW'(rde_pkg::ST_OK);
                n_last    = w_empty;
                n_state   = rde_pkg::S_IDLE;
            end
            default: begin
                n_state = rde_pkg::S_IDLE;
            end
        endcase

        n_out_valid = w_load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rde_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_element <= n_element;
            r_status  <= n_status;
            r_last    <= n_last;
        end
    end

    assign w_cnt_ext   = (CW + OW)'(r_count);
    assign o_out_valid = r_out_valid;
    assign o_element   = r_element;
    assign o_status    = r_status;
    assign o_last      = r_last;
    assign o_occupancy = w_cnt_ext[OW-1:0];
    assign o_reversed  = r_rev;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("element count above depth");

    a_rdata_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rde_pkg::S_RDATA |-> !r_out_valid)
        else $error("read data arrives while output register is occupied");

    a_pop_read_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == rde_pkg::OP_READ && !r_err && !w_empty)
        |=> r_state == rde_pkg::S_RDATA && !o_in_ready)
        else $error("popping read did not wait for RAM data");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == rde_pkg::OP_CLEAR)
        |=> r_count == '0 && !r_err && !r_rev && r_head == '0)
        else $error("clear left state behind");

endmodule
